// ===== rtl/set_assoc_lru_cache_tracker_macros.svh =====
// Assertion macros shared by the checker of the cache tracker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SET_ASSOC_LRU_CACHE_TRACKER_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TRACKER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SALRU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache tracker assertion failed");

// Antecedent implies consequent in the next cycle.
`define SALRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache tracker assertion failed");

// Condition holds at every sampled edge.
`define SALRU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("cache tracker assertion failed");

`endif

// ===== rtl/salru_pkg.sv =====
// Shared types and constants of the set-associative LRU cache tracker.
// No dependencies; imported by the way logic, the top level and the checker.
`default_nettype none

package salru_pkg;

  localparam int MAX_SET_BITS_DEF = 10;
  localparam int WAYS_DEF         = 8;
  localparam int ADDR_W           = 64;
  localparam int TAG_W            = 64;
  localparam int CNT_W            = 32;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 6;

  localparam logic [3:0]       SET_BITS_RESET   = 4'd4;
  localparam logic [5:0]       BLOCK_BITS_RESET = 6'd4;
  localparam logic [3:0]       WAYS_RESET       = 4'd1;
  localparam logic [CNT_W-1:0] CNT_TOP          = '1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_index_t;

  typedef struct packed {
    outcome_t outcome;
    logic     hit;
    logic     evict;
  } lookup_status_t;

endpackage

`default_nettype wire

// ===== rtl/salru_mem.sv =====
// Single-port-write, single-port-read synchronous set memory, one row per set.
// Read data is registered and holds until the next read. No dependencies.
`default_nettype none

module salru_mem #(
  parameter int DEPTH_BITS = 10,
  parameter int DATA_W     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [DEPTH_BITS-1:0] waddr,
  input  wire logic [DATA_W-1:0]     wdata,
  input  wire logic                  re,
  input  wire logic [DEPTH_BITS-1:0] raddr,
  output logic      [DATA_W-1:0]     rdata
);

  logic [DATA_W-1:0] mem [2**DEPTH_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/salru_way_logic.sv =====
// Tag compare, victim choice and LRU rank update for one set row.
// Depends on salru_pkg for tag width and the lookup status type.
`default_nettype none

module salru_way_logic import salru_pkg::*; #(
  parameter  int WAYS   = WAYS_DEF,
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int NW_W   = $clog2(WAYS + 1)
) (
  input  wire logic [TAG_W-1:0]                 tag_in,
  input  wire logic [NW_W-1:0]                  nw,
  input  wire logic [WAYS-1:0]                  valid_in,
  input  wire logic [WAYS-1:0][RANK_W-1:0]      rank_in,
  input  wire logic [WAYS-1:0][TAG_W-1:0]       tags_in,
  output logic      [WAYS-1:0]                  valid_out,
  output logic      [WAYS-1:0][RANK_W-1:0]      rank_out,
  output logic      [WAYS-1:0][TAG_W-1:0]       tags_out,
  output lookup_status_t                        status
);

  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]   in_use;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   free;
  logic              hit;
  logic              free_found;
  logic [WI-1:0]     hit_way;
  logic [WI-1:0]     free_way;
  logic [WI-1:0]     lru_way;
  logic [WI-1:0]     sel;
  logic [RANK_W-1:0] best_rank;
  logic [RANK_W-1:0] sel_rank;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = NW_W'(w) < nw;
      match[w]  = in_use[w] && valid_in[w] && (tags_in[w] == tag_in);
      free[w]   = in_use[w] && !valid_in[w];
    end
  end

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WI'(w);
      end
      if (free[w]) begin
        free_found = 1'b1;
        free_way   = WI'(w);
      end
    end
  end

  always_comb begin
    lru_way   = '0;
    best_rank = rank_in[0];
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (rank_in[w] < best_rank)) begin
        best_rank = rank_in[w];
        lru_way   = WI'(w);
      end
    end
  end

  assign sel      = hit ? hit_way : (free_found ? free_way : lru_way);
  assign sel_rank = rank_in[sel];

  always_comb begin
    valid_out = valid_in;
    tags_out  = tags_in;
    for (int w = 0; w < WAYS; w++) begin
      rank_out[w] = rank_in[w];
      if (in_use[w] && (rank_in[w] > sel_rank)) begin
        rank_out[w] = rank_in[w] - 1'b1;
      end
      if (WI'(w) == sel) begin
        rank_out[w] = RANK_W'(nw - NW_W'(1));
      end
    end
    if (!hit) begin
      valid_out[sel] = 1'b1;
      tags_out[sel]  = tag_in;
    end
  end

  always_comb begin
    status.hit   = hit;
    status.evict = !hit && !free_found;
    if (hit) begin
      status.outcome = OUT_HIT;
    end else if (free_found) begin
      status.outcome = OUT_FILL;
    end else begin
      status.outcome = OUT_EVICT;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_tracker.sv =====
// Set-associative LRU cache hit/miss tracker, top level.
// Uses salru_pkg, salru_mem (set rows) and salru_way_logic (lookup and update).
//
// Usage:
//   The input channel (in_valid/in_ready) carries one access beat: action and
//   address. A load or store gives one result beat on the output channel
//   (out_valid/out_ready); a modify gives two, the second with last_of_run set.
//   Action code 3 is accepted and gives no result.
//   Each access reads its set row from the set memory, compares tags, picks the
//   victim and writes the row back; the second lookup of a modify uses that row.
//   A result is registered after its set row is read and looked up, unless an
//   earlier result still waits. A new beat is accepted while a finished result
//   waits, but the next lookup holds until the output register is free.
//   The user must write configuration (cfg_write_en, cfg_index, cfg_data) only while
//   idle; the block does not enforce it. A write leaves the stored lines, ranks and totals untouched.
//   After reset a clearing pass writes all 2**MAX_SET_BITS set rows (1024 by
//   default), one per cycle; in_ready stays low until done.
//   A stalled receiver holds the result and all totals steady.
`default_nettype none

module set_assoc_lru_cache_tracker import salru_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int WAYS         = WAYS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             action,
  input  wire logic [ADDR_W-1:0]      address,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [1:0]             outcome,
  output logic                        last_of_run,
  output logic      [CNT_W-1:0]       hit_total,
  output logic      [CNT_W-1:0]       miss_total,
  output logic      [CNT_W-1:0]       eviction_total,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);

  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0][RANK_W-1:0]  rank;
    logic [WAYS-1:0][TAG_W-1:0]   tags;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t                  state;
  logic [MAX_SET_BITS-1:0] clr_idx;
  logic [3:0]              set_bits;
  logic [5:0]              block_bits;
  logic [3:0]              ways_in_use;
  logic [MAX_SET_BITS-1:0] cur_set;
  logic [TAG_W-1:0]        cur_tag;
  logic                    second_pending;
  logic                    use_fwd;
  row_t                    fwd_row;
  outcome_t                outcome_reg;
  logic [CNT_W-1:0]        hits_seen;
  logic [CNT_W-1:0]        misses_seen;
  logic [CNT_W-1:0]        evictions_seen;

  logic [4:0]              sb_eff;
  logic [6:0]              shift_amt;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_calc;
  logic [TAG_W-1:0]        tag_calc;
  logic [NW_W-1:0]         nw_eff;
  logic [4:0]              ways_ext;
  logic                    accept;
  logic                    out_free;
  logic                    do_access;
  logic [ROW_W-1:0]        rd_data;
  row_t                    row_cur;
  row_t                    row_new;
  row_t                    clear_row;
  lookup_status_t          status;
  logic                    mem_we;
  logic [MAX_SET_BITS-1:0] mem_waddr;
  logic [ROW_W-1:0]        mem_wdata;

  // Address split and effective configuration.
  assign sb_eff    = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                          : {1'b0, set_bits};
  assign shift_amt = 7'(sb_eff) + 7'(block_bits);
  assign tag_calc  = (shift_amt >= 7'd64) ? '0 : (address >> shift_amt);
  assign set_mask  = ~({MAX_SET_BITS{1'b1}} << sb_eff);
  assign set_calc  = MAX_SET_BITS'(address >> block_bits) & set_mask;
  assign ways_ext  = {1'b0, ways_in_use};

  always_comb begin
    if (ways_ext == 5'd0) begin
      nw_eff = NW_W'(1);
    end else if (ways_ext > 5'(WAYS)) begin
      nw_eff = NW_W'(WAYS);
    end else begin
      nw_eff = NW_W'(ways_ext);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign do_access = (state == ST_LOOK) && out_free;

  always_comb begin
    clear_row.valid = '0;
    clear_row.tags  = '0;
    for (int w = 0; w < WAYS; w++) begin
      clear_row.rank[w] = RANK_W'(w);
    end
  end

  assign row_cur = use_fwd ? fwd_row : row_t'(rd_data);

  assign mem_we    = (state == ST_CLEAR) || do_access;
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : cur_set;
  assign mem_wdata = (state == ST_CLEAR) ? ROW_W'(clear_row) : ROW_W'(row_new);

  salru_mem #(
    .DEPTH_BITS (MAX_SET_BITS),
    .DATA_W     (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (set_calc),
    .rdata (rd_data)
  );

  salru_way_logic #(
    .WAYS (WAYS)
  ) u_way_logic (
    .tag_in    (cur_tag),
    .nw        (nw_eff),
    .valid_in  (row_cur.valid),
    .rank_in   (row_cur.rank),
    .tags_in   (row_cur.tags),
    .valid_out (row_new.valid),
    .rank_out  (row_new.rank),
    .tags_out  (row_new.tags),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RESET;
      block_bits  <= BLOCK_BITS_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits    <= cfg_data[3:0];
        REG_BLOCK_BITS: block_bits  <= cfg_data[5:0];
        REG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      second_pending <= 1'b0;
      use_fwd        <= 1'b0;
      out_valid      <= 1'b0;
      last_of_run    <= 1'b0;
      outcome_reg    <= OUT_HIT;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else begin
      if (out_valid && out_ready && !do_access) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == {MAX_SET_BITS{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (action != ACT_NONE)) begin
            cur_set        <= set_calc;
            cur_tag        <= tag_calc;
            second_pending <= (action == ACT_MODIFY);
            use_fwd        <= 1'b0;
            state          <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            outcome_reg <= status.outcome;
            last_of_run <= !second_pending;
            if (status.hit) begin
              hits_seen <= (hits_seen == CNT_TOP) ? hits_seen : hits_seen + 1'b1;
            end else begin
              misses_seen <= (misses_seen == CNT_TOP) ? misses_seen : misses_seen + 1'b1;
            end
            if (status.evict) begin
              evictions_seen <= (evictions_seen == CNT_TOP) ? evictions_seen
                                                            : evictions_seen + 1'b1;
            end
            if (second_pending) begin
              second_pending <= 1'b0;
              use_fwd        <= 1'b1;
              fwd_row        <= row_new;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign outcome        = outcome_reg;
  assign hit_total      = hits_seen;
  assign miss_total     = misses_seen;
  assign eviction_total = evictions_seen;

endmodule

`default_nettype wire

// ===== rtl/salru_checker.sv =====
// Port-level checker of the cache tracker, bound to the top level.
// Depends on salru_pkg and set_assoc_lru_cache_tracker_macros.svh.
`default_nettype none
`include "set_assoc_lru_cache_tracker_macros.svh"

module salru_checker import salru_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic [1:0]       action,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       outcome,
  input wire logic             last_of_run,
  input wire logic [CNT_W-1:0] hit_total,
  input wire logic [CNT_W-1:0] miss_total,
  input wire logic [CNT_W-1:0] eviction_total
);

  // A stalled result beat and its miss total hold.
  `SALRU_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(last_of_run) && $stable(miss_total))

  // An accepted load, store or modify has a result beat waiting after its lookup.
  `SALRU_ASSERT_IMPL(a_result_follows, in_valid && in_ready && (action != ACT_NONE), ##2 out_valid)

  // The hit total never goes down.
  `SALRU_ASSERT_NEXT(a_hits_monotonic, !rst, hit_total >= $past(hit_total))

  // Every eviction is also a miss.
  `SALRU_ASSERT_ALWAYS(a_evict_le_miss, eviction_total <= miss_total)

endmodule

bind set_assoc_lru_cache_tracker salru_checker u_salru_checker (.*);

`default_nettype wire
